[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define ASSERT_NORST(lbl, clk_sig, prop) \
  lbl: assert property (@(posedge clk_sig) prop) \
    else $error("assertion failed");

`endif

[rtl/des_pkg.sv]
// Types and constants for the directory entry scanner.
package des_pkg;

  localparam int CFG_ADDR_W = 3;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TYPE_MASK    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_LOW   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_HIGH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MATCH_ANY    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CLUSTER_ENTS = 3'd4;

  // Verdict codes
  localparam logic [2:0] VERDICT_FREE     = 3'd0;
  localparam logic [2:0] VERDICT_FILTERED = 3'd1;
  localparam logic [2:0] VERDICT_MISMATCH = 3'd2;
  localparam logic [2:0] VERDICT_FOUND    = 3'd3;
  localparam logic [2:0] VERDICT_END      = 3'd4;
  localparam logic [2:0] VERDICT_IGNORED  = 3'd5;

  // File type codes
  localparam logic [1:0] FTYPE_FILE   = 2'd0;
  localparam logic [1:0] FTYPE_DIR    = 2'd1;
  localparam logic [1:0] FTYPE_VOLUME = 2'd2;

  localparam logic [7:0]  FIRST_END    = 8'h00;
  localparam logic [7:0]  FIRST_FREE   = 8'hE5;
  localparam logic [63:0] DOT_LOW      = 64'h2020_2020_2020_202E;
  localparam logic [63:0] DOTDOT_LOW   = 64'h2020_2020_2020_2E2E;
  localparam logic [23:0] SPACES_HIGH  = 24'h20_2020;
  localparam logic [22:0] ENTRY_BYTES  = 23'd32;
  localparam logic [22:0] PASSED_MAX   = 23'd2097152;
  localparam logic [11:0] MIN_ENTRIES  = 12'd16;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic        start_search;
    logic [10:0] start_entry;
    logic [63:0] entry_name_low;
    logic [23:0] entry_name_high;
    logic [7:0]  entry_attr;
  } item_t;

  typedef struct packed {
    logic [4:0]  type_mask;
    logic [63:0] target_name_low;
    logic [23:0] target_name_high;
    logic        match_any_name;
    logic [11:0] entries_eff;
  } cfg_t;

  typedef struct packed {
    logic [21:0] passed_bytes;
    logic [10:0] entry_index;
    logic        search_done;
  } state_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [21:0] byte_count;
    logic [15:0] entry_offset;
    logic [1:0]  file_type;
  } result_t;

endpackage

[rtl/des_cfg_regs.sv]
// Configuration registers; the cluster size is clamped as it is written.
module des_cfg_regs #(
  parameter int MAX_CLUSTER_ENTRIES = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [des_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [63:0]                    cfg_wr_data,
  output des_pkg::cfg_t                  cfg
);

  localparam logic [11:0] MAX_N = 12'(MAX_CLUSTER_ENTRIES);

  logic [4:0]  type_mask_r;
  logic [63:0] target_low_r;
  logic [23:0] target_high_r;
  logic        match_any_r;
  logic [11:0] entries_r;
  logic [11:0] entries_nxt;

  always_comb begin
    entries_nxt = cfg_wr_data[11:0];
    if (entries_nxt < des_pkg::MIN_ENTRIES) entries_nxt = des_pkg::MIN_ENTRIES;
    if (entries_nxt > MAX_N) entries_nxt = MAX_N;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_mask_r   <= 5'd1;
      target_low_r  <= '0;
      target_high_r <= '0;
      match_any_r   <= 1'b1;
      entries_r     <= des_pkg::MIN_ENTRIES;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        des_pkg::REG_TYPE_MASK:    type_mask_r   <= cfg_wr_data[4:0];
        des_pkg::REG_TARGET_LOW:   target_low_r  <= cfg_wr_data;
        des_pkg::REG_TARGET_HIGH:  target_high_r <= cfg_wr_data[23:0];
        des_pkg::REG_MATCH_ANY:    match_any_r   <= cfg_wr_data[0];
        des_pkg::REG_CLUSTER_ENTS: entries_r     <= entries_nxt;
        default: ;
      endcase
    end
  end

  assign cfg.type_mask        = type_mask_r;
  assign cfg.target_name_low  = target_low_r;
  assign cfg.target_name_high = target_high_r;
  assign cfg.match_any_name   = match_any_r;
  assign cfg.entries_eff      = entries_r;

endmodule

[rtl/des_classify.sv]
// Entry classification, byte count and index update for one entry.
module des_classify (
  input  des_pkg::item_t   item,
  input  des_pkg::cfg_t    cfg,
  input  des_pkg::state_t  st,
  output des_pkg::result_t res,
  output des_pkg::state_t  st_nxt
);

  logic [21:0] cur_passed;
  logic [10:0] cur_index;
  logic        cur_done;
  logic [22:0] sum;
  logic [21:0] sat_passed;
  logic [11:0] idx_inc;
  logic [10:0] idx_adv;
  logic [7:0]  first;
  logic        is_dot;
  logic        type_ok;
  logic        name_ok;
  logic [1:0]  ftype;

  always_comb begin
    // a start resets the running state before this entry is judged
    cur_passed = item.start_search ? '0 : st.passed_bytes;
    cur_done   = item.start_search ? 1'b0 : st.search_done;
    if (item.start_search)
      cur_index = ({1'b0, item.start_entry} < cfg.entries_eff) ? item.start_entry : '0;
    else
      cur_index = st.entry_index;

    sum        = {1'b0, cur_passed} + des_pkg::ENTRY_BYTES;
    sat_passed = (sum > des_pkg::PASSED_MAX) ? des_pkg::PASSED_MAX[21:0] : sum[21:0];

    idx_inc = {1'b0, cur_index} + 12'd1;
    idx_adv = (idx_inc >= cfg.entries_eff) ? '0 : idx_inc[10:0];

    first  = item.entry_name_low[7:0];
    is_dot = (item.entry_name_high == des_pkg::SPACES_HIGH) &&
             ((item.entry_name_low == des_pkg::DOT_LOW) ||
              (item.entry_name_low == des_pkg::DOTDOT_LOW));
    type_ok = !(item.entry_attr[2] && !cfg.type_mask[2]) &&
              !(item.entry_attr[1] && !cfg.type_mask[3]) &&
              !(item.entry_attr[3] && !cfg.type_mask[4]) &&
              (is_dot ? cfg.type_mask[1] : cfg.type_mask[0]);
    name_ok = cfg.match_any_name ||
              ((item.entry_name_low == cfg.target_name_low) &&
               (item.entry_name_high == cfg.target_name_high));

    if (item.entry_attr[3])      ftype = des_pkg::FTYPE_VOLUME;
    else if (item.entry_attr[4]) ftype = des_pkg::FTYPE_DIR;
    else                         ftype = des_pkg::FTYPE_FILE;

    st_nxt.passed_bytes = cur_passed;
    st_nxt.entry_index  = cur_index;
    st_nxt.search_done  = cur_done;
    res.byte_count      = cur_passed;
    res.entry_offset    = {cur_index, 5'b0};
    res.file_type       = ftype;

    if (cur_done) begin
      res.verdict   = des_pkg::VERDICT_IGNORED;
      res.file_type = des_pkg::FTYPE_FILE;
    end else if (first == des_pkg::FIRST_END) begin
      res.verdict        = des_pkg::VERDICT_END;
      st_nxt.search_done = 1'b1;
    end else if (first == des_pkg::FIRST_FREE) begin
      res.verdict         = des_pkg::VERDICT_FREE;
      res.byte_count      = sat_passed;
      st_nxt.passed_bytes = sat_passed;
      st_nxt.entry_index  = idx_adv;
    end else if (!type_ok) begin
      res.verdict         = des_pkg::VERDICT_FILTERED;
      res.byte_count      = sat_passed;
      st_nxt.passed_bytes = sat_passed;
      st_nxt.entry_index  = idx_adv;
    end else if (name_ok) begin
      res.verdict         = des_pkg::VERDICT_FOUND;
      res.byte_count      = sat_passed;
      st_nxt.passed_bytes = sat_passed;
      st_nxt.search_done  = 1'b1;
    end else begin
      res.verdict         = des_pkg::VERDICT_MISMATCH;
      res.byte_count      = sat_passed;
      st_nxt.passed_bytes = sat_passed;
      st_nxt.entry_index  = idx_adv;
    end
  end

endmodule

[rtl/directory_entry_scanner.sv]
// Top level of the directory entry scanner: input stage, classifier, result stage.
//
//   channel  direction  tdata / tuser                               handshake
//   in_      slave      entry fields, start flag on tuser           tvalid/tready
//   out_     master     verdict, byte count, offset, file type      tvalid/tready
//   cfg_     write      register index and 64-bit data              cfg_wr_en
//
// One entry per cycle unless out_ stalls; each passes both stages before out_tvalid.
// The only loop is the search state (count, index, done), registered per entry.
// Reset (rst_n low, synchronous) empties both stages and leaves the search done.
// A stalled out_ holds its result; in_tready drops only when both stages are full.
module directory_entry_scanner #(
  parameter int MAX_CLUSTER_ENTRIES = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [10:0] start_entry, [74:11] entry_name_low, [98:75] entry_name_high,
  // [106:99] entry_attr, [111:107] zero
  input  logic [des_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] start_search
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] verdict, [24:3] byte_count, [40:25] entry_offset, [42:41] file_type,
  // [47:43] zero
  output logic [des_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [des_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [63:0]                     cfg_wr_data
);

  des_pkg::cfg_t    cfg;
  des_pkg::item_t   item_r;
  des_pkg::state_t  st_r;
  des_pkg::state_t  st_nxt;
  des_pkg::result_t res;
  des_pkg::result_t res_r;
  logic             in_valid_r;
  logic             out_valid_r;
  logic             adv;

  des_cfg_regs #(
    .MAX_CLUSTER_ENTRIES(MAX_CLUSTER_ENTRIES)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  des_classify u_classify (
    .item   (item_r),
    .cfg    (cfg),
    .st     (st_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // entry moves into the result stage when that stage is empty or draining
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      st_r.passed_bytes <= '0;
      st_r.entry_index  <= '0;
      st_r.search_done  <= 1'b1;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.start_search    <= in_tuser;
      item_r.start_entry     <= in_tdata[10:0];
      item_r.entry_name_low  <= in_tdata[74:11];
      item_r.entry_name_high <= in_tdata[98:75];
      item_r.entry_attr      <= in_tdata[106:99];
    end
    if (adv) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.file_type, res_r.entry_offset,
                       res_r.byte_count, res_r.verdict};

endmodule

[rtl/des_checker.sv]
// Port-level checks for the directory entry scanner, bound to the top level.
`include "assert_macros.svh"

module des_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [des_pkg::OUT_DATA_W-1:0] out_tdata
);

  // result held while stalled
  `ASSERT_CLK(a_stall_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // reset leaves no result pending
  `ASSERT_NORST(a_reset_empty, clk, !rst_n |=> !out_tvalid)

  // offsets are whole entries
  `ASSERT_CLK(a_offset_aligned, clk, rst_n, out_tvalid |-> out_tdata[29:25] == 5'd0)

  // a found entry counts itself
  `ASSERT_CLK(a_found_counted, clk, rst_n, out_tvalid && out_tdata[2:0] == des_pkg::VERDICT_FOUND |-> out_tdata[24:3] != 22'd0)

  // ignored entries report no type
  `ASSERT_CLK(a_ignored_type, clk, rst_n, out_tvalid && out_tdata[2:0] == des_pkg::VERDICT_IGNORED |-> out_tdata[42:41] == des_pkg::FTYPE_FILE)

endmodule

bind directory_entry_scanner des_checker u_des_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/directory_entry_scanner_tb.sv]
// Self-checking stream testbench for the directory entry scanner.
module directory_entry_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import des_pkg::*;

  localparam logic [11:0] MAX_ENTS = 12'd2048;

  // attribute byte flags
  localparam logic [7:0] ATTR_HIDDEN = 8'h02;
  localparam logic [7:0] ATTR_SYSTEM = 8'h04;
  localparam logic [7:0] ATTR_VOLUME = 8'h08;
  localparam logic [7:0] ATTR_DIR    = 8'h10;
  localparam logic [7:0] ATTR_ARCH   = 8'h20;

  // type_mask enables
  localparam logic [4:0] ALLOW_NORMAL = 5'h01;
  localparam logic [4:0] ALLOW_DOT    = 5'h02;
  localparam logic [4:0] ALLOW_SYSTEM = 5'h04;
  localparam logic [4:0] ALLOW_HIDDEN = 5'h08;
  localparam logic [4:0] ALLOW_VOLUME = 5'h10;
  localparam logic [4:0] ALLOW_ALL    = 5'h1F;
  localparam logic [4:0] ALLOW_NONE   = 5'h00;

  // "README  TXT"
  localparam logic [63:0] README_LOW  = 64'h2020_454D_4441_4552;
  localparam logic [23:0] README_HIGH = 24'h54_5854;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [63:0]           cfg_wr_data = '0;

  directory_entry_scanner dut (.*);

  always #5 clk = ~clk;

  // register copies
  logic [4:0]  m_type_mask = 5'd1;
  logic [63:0] m_target_low = '0;
  logic [23:0] m_target_high = '0;
  logic        m_match_any = 1'b1;
  logic [11:0] m_cluster_ents = 12'd16;

  // search state
  logic [21:0] srch_bytes = '0;
  logic [10:0] srch_index = '0;
  logic        srch_done = 1'b1;

  item_t   entries_pending[$];
  result_t verdicts_due[$];
  item_t   cur_entry;
  result_t got, want;
  int      errors = 0;
  int      random_items = 0;
  logic    no_gaps = 1'b0;

  function automatic item_t mk_entry(logic start, logic [10:0] sidx, logic [63:0] lo,
                                     logic [23:0] hi, logic [7:0] attr);
    item_t e;
    e.start_search = start;
    e.start_entry = sidx;
    e.entry_name_low = lo;
    e.entry_name_high = hi;
    e.entry_attr = attr;
    return e;
  endfunction

  function automatic logic [11:0] cluster_size();
    if (m_cluster_ents < MIN_ENTRIES) return MIN_ENTRIES;
    if (m_cluster_ents > MAX_ENTS) return MAX_ENTS;
    return m_cluster_ents;
  endfunction

  function automatic logic type_ok(item_t e);
    if ((e.entry_attr & ATTR_SYSTEM) != 0 && (m_type_mask & ALLOW_SYSTEM) == 0) return 1'b0;
    if ((e.entry_attr & ATTR_HIDDEN) != 0 && (m_type_mask & ALLOW_HIDDEN) == 0) return 1'b0;
    if ((e.entry_attr & ATTR_VOLUME) != 0 && (m_type_mask & ALLOW_VOLUME) == 0) return 1'b0;
    if (e.entry_name_high == SPACES_HIGH &&
        (e.entry_name_low == DOT_LOW || e.entry_name_low == DOTDOT_LOW))
      return (m_type_mask & ALLOW_DOT) != 0;
    return (m_type_mask & ALLOW_NORMAL) != 0;
  endfunction

  // Advances the search state by one entry and returns the verdict it earns.
  function automatic result_t classify_entry(item_t e);
    result_t r;
    logic [11:0] n;
    logic [11:0] nxt;
    logic [22:0] sum;
    n = cluster_size();
    if (e.start_search) begin
      srch_bytes = '0;
      srch_done = 1'b0;
      srch_index = ({1'b0, e.start_entry} < n) ? e.start_entry : '0;
    end
    r.byte_count = srch_bytes;
    r.entry_offset = {srch_index, 5'd0};
    r.file_type = FTYPE_FILE;
    if (srch_done) begin
      r.verdict = VERDICT_IGNORED;
      return r;
    end
    if ((e.entry_attr & ATTR_VOLUME) != 0) r.file_type = FTYPE_VOLUME;
    else if ((e.entry_attr & ATTR_DIR) != 0) r.file_type = FTYPE_DIR;
    if (e.entry_name_low[7:0] == FIRST_END) begin
      // end marker: count and index stay put
      r.verdict = VERDICT_END;
      srch_done = 1'b1;
      return r;
    end
    sum = {1'b0, srch_bytes} + ENTRY_BYTES;
    if (sum > PASSED_MAX) sum = PASSED_MAX;
    srch_bytes = sum[21:0];
    r.byte_count = srch_bytes;
    if (e.entry_name_low[7:0] == FIRST_FREE) begin
      r.verdict = VERDICT_FREE;
    end else if (!type_ok(e)) begin
      r.verdict = VERDICT_FILTERED;
    end else if (m_match_any ||
                 (e.entry_name_low == m_target_low && e.entry_name_high == m_target_high)) begin
      r.verdict = VERDICT_FOUND;
      srch_done = 1'b1;
    end else begin
      r.verdict = VERDICT_MISMATCH;
    end
    if (!srch_done) begin
      nxt = {1'b0, srch_index} + 12'd1;
      srch_index = (nxt >= n) ? '0 : nxt[10:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // driver: one entry per transfer, predicted as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) verdicts_due.push_back(classify_entry(cur_entry));
      if (entries_pending.size() > 0 && (no_gaps || $urandom_range(99) >= 22)) begin
        cur_entry = entries_pending.pop_front();
        in_tdata <= {5'd0, cur_entry.entry_attr, cur_entry.entry_name_high,
                     cur_entry.entry_name_low, cur_entry.start_entry};
        in_tuser <= cur_entry.start_search;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= no_gaps || $urandom_range(99) >= 22;
      if (out_tvalid && out_tready) begin
        got.verdict = out_tdata[2:0];
        got.byte_count = out_tdata[24:3];
        got.entry_offset = out_tdata[40:25];
        got.file_type = out_tdata[42:41];
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result transfer with none expected, verdict %0d",
                                    got.verdict));
        end else begin
          want = verdicts_due.pop_front();
          if (got.verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d, expected %0d", got.verdict, want.verdict));
          if (got.byte_count !== want.byte_count)
            report_mismatch($sformatf("byte_count %0d, expected %0d",
                                      got.byte_count, want.byte_count));
          if (got.entry_offset !== want.entry_offset)
            report_mismatch($sformatf("entry_offset %0d, expected %0d",
                                      got.entry_offset, want.entry_offset));
          if (got.file_type !== want.file_type)
            report_mismatch($sformatf("file_type %0d, expected %0d",
                                      got.file_type, want.file_type));
        end
      end
    end
  end

  function automatic logic [63:0] rand_name();
    logic [63:0] lo;
    lo = {$urandom, $urandom};
    if (lo[7:0] == FIRST_END || lo[7:0] == FIRST_FREE) lo[7:0] = 8'h41;
    return lo;
  endfunction

  function automatic logic [7:0] rand_attr();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return ATTR_DIR;
      2: return ATTR_HIDDEN;
      3: return ATTR_SYSTEM;
      4: return ATTR_VOLUME;
      5: return ATTR_ARCH;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic item_t body_entry();
    item_t e;
    int pick;
    int flip;
    e = mk_entry(1'b0, 11'($urandom_range(2047)), rand_name(), 24'($urandom), rand_attr());
    pick = $urandom_range(99);
    if (pick < 12) begin
      e.entry_name_low[7:0] = FIRST_FREE;
    end else if (pick < 24) begin
      e.entry_name_low = pick[0] ? DOT_LOW : DOTDOT_LOW;
      e.entry_name_high = SPACES_HIGH;
    end else if (pick < 38) begin
      e.entry_name_low = m_target_low;
      e.entry_name_high = m_target_high;
      // near miss: one name bit off
      if (pick >= 33) begin
        flip = $urandom_range(87);
        if (flip < 64) e.entry_name_low[flip] = ~e.entry_name_low[flip];
        else e.entry_name_high[flip - 64] = ~e.entry_name_high[flip - 64];
      end
    end
    return e;
  endfunction

  // start entry, a body of entries, usually a terminator, then a few stragglers
  task automatic queue_search();
    item_t e;
    logic [11:0] n;
    n = cluster_size();
    e = body_entry();
    e.start_search = 1'b1;
    if ($urandom_range(4) != 0) e.start_entry = 11'($urandom_range(n - 1));
    entries_pending.push_back(e);
    repeat ($urandom_range(8)) begin
      e = body_entry();
      if ($urandom_range(9) == 0)
        e = mk_entry(1'($urandom), 11'($urandom), {$urandom, $urandom}, 24'($urandom),
                     8'($urandom));
      entries_pending.push_back(e);
    end
    e = body_entry();
    case ($urandom_range(3))
      0, 1: e.entry_name_low[7:0] = FIRST_END;
      2: begin
        e.entry_name_low = m_target_low;
        e.entry_name_high = m_target_high;
      end
      default: ;
    endcase
    entries_pending.push_back(e);
    repeat ($urandom_range(2)) entries_pending.push_back(body_entry());
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= data;
    case (idx)
      REG_TYPE_MASK:    m_type_mask = data[4:0];
      REG_TARGET_LOW:   m_target_low = data;
      REG_TARGET_HIGH:  m_target_high = data[23:0];
      REG_MATCH_ANY:    m_match_any = data[0];
      REG_CLUSTER_ENTS: m_cluster_ents = data[11:0];
      default: ;
    endcase
  endtask

  // upper bits beyond each register carry junk
  task automatic set_config(logic [4:0] mask, logic [63:0] tlo, logic [23:0] thi,
                            logic any, logic [11:0] ents);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_TYPE_MASK, {junk[63:5], mask});
    write_reg(REG_TARGET_LOW, tlo);
    write_reg(REG_TARGET_HIGH, {junk[63:24], thi});
    write_reg(REG_MATCH_ANY, {junk[63:1], any});
    write_reg(REG_CLUSTER_ENTS, {junk[63:12], ents});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (entries_pending.size() != 0 || in_tvalid || verdicts_due.size() != 0);
  endtask

  function automatic logic [11:0] pick_cluster();
    case ($urandom_range(7))
      0: return 12'd0;
      1: return 12'd15;
      2: return MIN_ENTRIES;
      3: return 12'd17;
      4: return MAX_ENTS;
      5: return 12'($urandom_range(4095, 2049));
      default: return 12'($urandom_range(2048, 16));
    endcase
  endfunction

  initial begin
    int ph;
    logic [63:0] nm;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: normal entries only, any name, 16 entries per cluster
    entries_pending.push_back(mk_entry(1'b0, 11'd3, README_LOW, README_HIGH, 8'h00));
    entries_pending.push_back(mk_entry(1'b1, 11'd15, {README_LOW[63:8], FIRST_FREE},
                                       README_HIGH, 8'h00));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, {README_LOW[63:8], FIRST_FREE},
                                       README_HIGH, 8'h00));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, README_LOW, README_HIGH, ATTR_SYSTEM));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, README_LOW, README_HIGH, ATTR_HIDDEN));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, README_LOW, README_HIGH, ATTR_VOLUME));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, DOT_LOW, SPACES_HIGH, ATTR_DIR));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, README_LOW, README_HIGH, ATTR_DIR));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, README_LOW, README_HIGH, 8'h00));
    entries_pending.push_back(mk_entry(1'b1, 11'd2047, '0, '0, 8'h00));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, README_LOW, README_HIGH, 8'h00));
    drain();

    // all types, exact all-ones target, oversized cluster acting as the maximum
    set_config(ALLOW_ALL, '1, '1, 1'b0, 12'd4095);
    entries_pending.push_back(mk_entry(1'b1, 11'd2047, README_LOW, README_HIGH, ATTR_ARCH));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, DOT_LOW, SPACES_HIGH, ATTR_DIR));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, DOTDOT_LOW, SPACES_HIGH,
                                       ATTR_DIR | ATTR_HIDDEN));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, '1, '1, 8'hFF));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, '1, '1, 8'h00));
    entries_pending.push_back(mk_entry(1'b1, 11'd5, 64'hFFFF_FFFF_FFFF_FF00, '1, 8'hFF));
    drain();

    // nothing passes the filter; undersized cluster acting as the minimum
    set_config(ALLOW_NONE, README_LOW, README_HIGH, 1'b1, 12'd0);
    entries_pending.push_back(mk_entry(1'b1, 11'd16, README_LOW, README_HIGH, 8'h00));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, DOT_LOW, SPACES_HIGH, ATTR_DIR));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, {README_LOW[63:8], FIRST_FREE},
                                       README_HIGH, 8'h00));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, README_LOW, README_HIGH,
                                       ATTR_SYSTEM | ATTR_VOLUME));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, '0, README_HIGH, 8'h00));
    drain();

    // a run of free entries across the cluster end, no gaps on either side
    set_config(ALLOW_NORMAL, README_LOW, README_HIGH, 1'b0, MAX_ENTS);
    no_gaps = 1'b1;
    nm = rand_name();
    entries_pending.push_back(mk_entry(1'b1, 11'd2030, {nm[63:8], FIRST_FREE},
                                       24'($urandom), rand_attr()));
    repeat (30) begin
      nm = rand_name();
      entries_pending.push_back(mk_entry(1'b0, 11'($urandom), {nm[63:8], FIRST_FREE},
                                         24'($urandom), rand_attr()));
    end
    entries_pending.push_back(mk_entry(1'b0, 11'd0, README_LOW, README_HIGH, 8'h00));
    entries_pending.push_back(mk_entry(1'b0, 11'd0, README_LOW, README_HIGH, 8'h00));
    drain();
    no_gaps = 1'b0;

    // random searches under a fresh setting each round
    ph = 0;
    while (random_items < 400) begin
      set_config((ph == 0) ? ALLOW_ALL : 5'($urandom_range(31)), rand_name(),
                 24'($urandom), (ph == 1) || ($urandom_range(3) == 0),
                 (ph == 0) ? MIN_ENTRIES : pick_cluster());
      while (entries_pending.size() < 50) queue_search();
      random_items += entries_pending.size();
      drain();
      ph++;
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** directory_entry_scanner: PASSED **");
    end else begin
      $display("** directory_entry_scanner: FAILED **");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** directory_entry_scanner: FAILED **");
    $finish;
  end

endmodule
